// ===== src/mpr_pkg.sv =====
`timescale 1ns / 1ps

package mpr_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_CONTENT_FLAGS = 3'd0;
  localparam logic [2:0] REG_RESOLUTION    = 3'd1;
  localparam logic [2:0] REG_CENTER_LON    = 3'd2;
  localparam logic [2:0] REG_CENTER_LAT    = 3'd3;
  localparam logic [2:0] REG_LEVEL         = 3'd4;
  localparam logic [2:0] REG_BLOCK_LENGTH  = 3'd5;

  localparam logic [4:0]  RES_FULL     = 5'd24;
  localparam logic [23:0] POS_MAX      = 24'hFF_FFFF;
  localparam logic [3:0]  RECORD_BYTES = 4'd8;

  // Input word: one block byte
  typedef struct packed {
    logic [7:0] data_byte;
    logic       block_start;
  } in_t;

  // Result word: one point record
  typedef struct packed {
    logic [7:0]         poi_type;
    logic               sub_found;
    logic [7:0]         subtype;
    logic [21:0]        label_offset;
    logic signed [31:0] lon_units;
    logic signed [31:0] lat_units;
    logic [3:0]         end_level;
  } out_t;

  // Configuration register file contents
  typedef struct packed {
    logic [3:0]  content_flags;
    logic [4:0]  resolution;
    logic [23:0] center_lon;
    logic [23:0] center_lat;
    logic [3:0]  level;
    logic [23:0] block_length;
  } cfg_t;

  // Raw record handed from the parser to the coordinate stage
  typedef struct packed {
    logic [63:0] rec_bytes;
    logic        sub_found;
    logic [7:0]  subtype;
  } rec_t;

endpackage

// ===== src/mpr_cfg_regs.sv =====
`timescale 1ns / 1ps

module mpr_cfg_regs (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [2:0]       cfg_index_i,
  input  logic [23:0]      cfg_data_i,
  output mpr_pkg::cfg_t    cfg_o
);

  mpr_pkg::cfg_t cfg_q;
  mpr_pkg::cfg_t cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // Register write decode; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        mpr_pkg::REG_CONTENT_FLAGS: cfg_d.content_flags = cfg_data_i[3:0];
        mpr_pkg::REG_RESOLUTION:    cfg_d.resolution    = cfg_data_i[4:0];
        mpr_pkg::REG_CENTER_LON:    cfg_d.center_lon    = cfg_data_i;
        mpr_pkg::REG_CENTER_LAT:    cfg_d.center_lat    = cfg_data_i;
        mpr_pkg::REG_LEVEL:         cfg_d.level         = cfg_data_i[3:0];
        mpr_pkg::REG_BLOCK_LENGTH:  cfg_d.block_length  = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{content_flags: 4'd0, resolution: mpr_pkg::RES_FULL, center_lon: 24'd0,
                 center_lat: 24'd0, level: 4'd0, block_length: 24'd0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== src/mpr_parser.sv =====
`timescale 1ns / 1ps

module mpr_parser (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mpr_pkg::cfg_t  cfg_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  mpr_pkg::in_t   in_data_i,
  input  logic           out_free_i,
  output logic           rec_valid_o,
  output mpr_pkg::rec_t  rec_o
);

  // Input register
  logic          s1_valid_q;
  mpr_pkg::in_t  s1_q;
  logic          step;

  // Parse state
  logic [23:0] pos_q, pos_d;
  logic [23:0] send_q, send_d;
  logic [63:0] buf_q, buf_d;
  logic [3:0]  fill_q, fill_d;
  logic        pend_q, pend_d;
  logic [7:0]  plow_q, plow_d;

  // State as seen after an optional block restart
  logic        start;
  logic [23:0] pos_e, send_e;
  logic [3:0]  fill_e;
  logic        pend_e;
  logic [7:0]  plow_e;

  logic        has_std, has_idx, has_pl, has_pg, has_pts;
  logic [1:0]  n_ptr;
  logic [2:0]  two_n;
  logic        use_ptr;
  logic [23:0] first_pos, end_raw, end_pos;
  logic [24:0] pos_p1;
  logic        in_sect;
  logic [15:0] ptr_word;
  logic [63:0] buf_new;

  assign step       = s1_valid_q && out_free_i;
  assign in_ready_o = !s1_valid_q || out_free_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_q <= in_data_i;
    end
  end

  // Block restart view
  assign start  = s1_q.block_start;
  assign pos_e  = start ? '0 : pos_q;
  assign send_e = start ? '0 : send_q;
  assign fill_e = start ? '0 : fill_q;
  assign pend_e = start ? 1'b0 : pend_q;
  assign plow_e = start ? '0 : plow_q;

  // Section layout from the content flags
  assign has_std = cfg_i.content_flags[0];
  assign has_idx = cfg_i.content_flags[1];
  assign has_pl  = cfg_i.content_flags[2];
  assign has_pg  = cfg_i.content_flags[3];
  assign has_pts = has_std || has_idx;

  assign n_ptr = {1'b0, has_idx && has_std} + {1'b0, has_pl && has_pts}
               + {1'b0, has_pg && (has_pts || has_pl)};
  assign two_n     = {n_ptr, 1'b0};
  assign use_ptr   = (n_ptr != 2'd0) && ({21'd0, two_n} <= cfg_i.block_length);
  assign first_pos = use_ptr ? {21'd0, two_n} : '0;
  assign end_raw   = use_ptr ? send_e : cfg_i.block_length;
  assign end_pos   = (end_raw > cfg_i.block_length) ? cfg_i.block_length : end_raw;
  assign pos_p1    = {1'b0, pos_e} + 25'd1;
  assign in_sect   = (pos_e >= first_pos) && (pos_e < end_pos);
  assign ptr_word  = {s1_q.data_byte, plow_e};

  always_comb begin
    buf_new = buf_q;
    buf_new[{fill_e[2:0], 3'b000} +: 8] = s1_q.data_byte;
  end

  // Per-byte parse step
  always_comb begin
    pos_d       = pos_q;
    send_d      = send_q;
    buf_d       = buf_q;
    fill_d      = fill_q;
    pend_d      = pend_q;
    plow_d      = plow_q;
    rec_valid_o = 1'b0;
    rec_o       = '0;
    rec_o.rec_bytes = buf_q;
    if (step) begin
      pos_d  = (pos_e == mpr_pkg::POS_MAX) ? pos_e : pos_e + 24'd1;
      send_d = send_e;
      fill_d = fill_e;
      pend_d = pend_e;
      plow_d = plow_e;
      if (start && pend_q) begin
        // restart flushes the held record without its subtype
        rec_valid_o = 1'b1;
      end
      if (pend_e) begin
        rec_valid_o       = 1'b1;
        rec_o.sub_found   = pos_e < end_pos;
        rec_o.subtype     = (pos_e < end_pos) ? s1_q.data_byte : 8'd0;
        pend_d            = 1'b0;
        fill_d            = '0;
      end else if (has_pts) begin
        if (use_ptr && pos_e == 24'd0) begin
          plow_d = s1_q.data_byte;
        end else if (use_ptr && pos_e == 24'd1) begin
          send_d = ({8'd0, ptr_word} > cfg_i.block_length) ?
                   cfg_i.block_length : {8'd0, ptr_word};
        end else if (in_sect && fill_e < mpr_pkg::RECORD_BYTES) begin
          buf_d  = buf_new;
          fill_d = fill_e + 4'd1;
          if (fill_e == mpr_pkg::RECORD_BYTES - 4'd1) begin
            if (buf_new[31] && pos_p1 < {1'b0, end_pos}) begin
              pend_d = 1'b1;
            end else begin
              rec_valid_o     = 1'b1;
              rec_o.rec_bytes = buf_new;
              fill_d          = '0;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      send_q <= '0;
      fill_q <= '0;
      pend_q <= 1'b0;
      plow_q <= '0;
    end else begin
      pos_q  <= pos_d;
      send_q <= send_d;
      fill_q <= fill_d;
      pend_q <= pend_d;
      plow_q <= plow_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

  // A held record always has all eight bytes
  a_pend_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> fill_q == mpr_pkg::RECORD_BYTES)
    else $error("subtype pending without a full record");

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= mpr_pkg::RECORD_BYTES)
    else $error("record fill overran");

  // A stalled byte is held in the input register
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_free_i |=> s1_valid_q && $stable(s1_q))
    else $error("input register lost a stalled byte");

  a_no_emit_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_valid_o |-> out_free_i)
    else $error("record produced while result register busy");

endmodule

// ===== src/mpr_coord.sv =====
`timescale 1ns / 1ps

module mpr_coord (
  input  mpr_pkg::cfg_t  cfg_i,
  input  mpr_pkg::rec_t  rec_i,
  output mpr_pkg::out_t  res_o
);

  logic [4:0]  shift;
  logic [31:0] dlon, dlat, clon, clat;

  // Delta scaling: shift saturates at zero for fine resolutions
  assign shift = (cfg_i.resolution > mpr_pkg::RES_FULL) ? 5'd0
               : mpr_pkg::RES_FULL - cfg_i.resolution;
  assign dlon  = {{16{rec_i.rec_bytes[47]}}, rec_i.rec_bytes[47:32]};
  assign dlat  = {{16{rec_i.rec_bytes[63]}}, rec_i.rec_bytes[63:48]};
  assign clon  = {{8{cfg_i.center_lon[23]}}, cfg_i.center_lon};
  assign clat  = {{8{cfg_i.center_lat[23]}}, cfg_i.center_lat};

  always_comb begin
    res_o              = '0;
    res_o.poi_type     = rec_i.rec_bytes[7:0];
    res_o.sub_found    = rec_i.sub_found;
    res_o.subtype      = rec_i.subtype;
    res_o.label_offset = rec_i.rec_bytes[29:8];
    res_o.lon_units    = clon + (dlon << shift);
    res_o.lat_units    = clat + (dlat << shift);
    res_o.end_level    = cfg_i.level;
  end

endmodule

// ===== src/map_point_record_parser.sv =====
`timescale 1ns / 1ps
// Result path: a byte that completes a record reaches the output through the input register,
// then the result register; a subtype byte completes its held record.
// Throughput: one byte per cycle while the result side takes words.
// Reset: rst_ni asynchronous active low; clears parse state, handshake flags, and
// configuration (resolution 24, all other registers 0).

module map_point_record_parser (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  mpr_pkg::in_t    in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output mpr_pkg::out_t   out_data_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [2:0]      cfg_index_i,
  input  logic [23:0]     cfg_data_i
);

  mpr_pkg::cfg_t  cfg;
  mpr_pkg::rec_t  rec;
  mpr_pkg::out_t  res;
  logic           rec_valid;
  logic           out_free;
  logic           out_valid_q;
  mpr_pkg::out_t  out_q;

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  mpr_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  mpr_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_free_i  (out_free),
    .rec_valid_o (rec_valid),
    .rec_o       (rec)
  );

  mpr_coord u_coord (
    .cfg_i (cfg),
    .rec_i (rec),
    .res_o (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rec_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rec_valid) begin
      out_q <= res;
    end
  end

  a_keep_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(out_q))
    else $error("result word dropped or changed while stalled");

endmodule
